>>> src/clc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package clc_pkg;

  localparam int CODE_LENGTH_DEFAULT = 4;

  localparam int SAMPLE_W = 12;
  localparam int SECRET_W = 16;
  localparam int WARMUP_W = 16;
  localparam int DIGIT_W  = 4;
  localparam int MODE_W   = 2;
  localparam int COUNT_W  = 3;
  localparam int SECRET_DIGITS = SECRET_W / DIGIT_W;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

  localparam logic [MODE_W-1:0] MODE_DISARMED  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ARMED     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TRIGGERED = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SECRET_CODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_POLLS   = 2'd3;

  localparam logic [SECRET_W-1:0] SECRET_RESET = 16'h5555;
  localparam logic [SAMPLE_W-1:0] LOW_RESET    = 12'd1000;
  localparam logic [SAMPLE_W-1:0] HIGH_RESET   = 12'd3000;
  localparam logic [WARMUP_W-1:0] WARMUP_RESET = 16'd50;

  typedef struct packed {
    logic [SECRET_W-1:0] secret_code;
    logic [SAMPLE_W-1:0] low_threshold;
    logic [SAMPLE_W-1:0] high_threshold;
    logic [WARMUP_W-1:0] warmup_polls;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] joystick_sample;
    logic                enter_press;
    logic                delete_press;
    logic                motion_edge;
    logic                sound_event;
  } poll_t;

  typedef struct packed {
    logic [MODE_W-1:0]  alarm_mode;
    logic [DIGIT_W-1:0] selected_digit;
    logic [COUNT_W-1:0] entered_count;
  } result_t;

endpackage

`default_nettype wire

>>> src/clc_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface clc_in_if import clc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] joystick_sample;
  logic                enter_press;
  logic                delete_press;
  logic                motion_edge;
  logic                sound_event;

  modport source (
    output valid, joystick_sample, enter_press, delete_press, motion_edge, sound_event,
    input  ready
  );
  modport sink (
    input  valid, joystick_sample, enter_press, delete_press, motion_edge, sound_event,
    output ready
  );
endinterface

interface clc_out_if import clc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  alarm_mode;
  logic [DIGIT_W-1:0] selected_digit;
  logic [COUNT_W-1:0] entered_count;

  modport source (
    output valid, alarm_mode, selected_digit, entered_count,
    input  ready
  );
  modport sink (
    input  valid, alarm_mode, selected_digit, entered_count,
    output ready
  );
endinterface

interface clc_cfg_if import clc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

>>> src/code_lock_alarm_controller.sv
`timescale 1ns / 1ps
`default_nettype none

// Code-lock intrusion alarm controller. Each transfer on in_i is one poll of
// the joystick, the enter and delete buttons, the motion edge and the sound
// event. Each poll produces exactly one transfer on out_o with the alarm mode,
// the selected digit and the number of code digits entered after that poll.
// Registers are written through cfg_i (index 0 secret code, 1 low threshold,
// 2 high threshold, 3 warm-up polls); cfg_i is always ready, and writes are
// expected only while no poll is in flight.
// A poll is registered at the input, processed combinationally against the
// controller state, and its result is registered at the output, from where
// it is offered on out_o. One poll per cycle is sustained while the receiver
// keeps out_o ready; in_i stays ready while the input register can move on.
// When the receiver stalls, the output register holds its result and the
// input register holds one more poll; in_i drops ready only when both are
// full. Reset leaves the alarm armed with an empty entry, digit zero, a
// cleared motion latch, the warm-up count at zero and the registers at their
// default values.
module code_lock_alarm_controller import clc_pkg::*; #(
  parameter int CODE_LENGTH = CODE_LENGTH_DEFAULT
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  clc_in_if.sink     in_i,
  clc_out_if.source  out_o,
  clc_cfg_if.sink    cfg_i
);

  cfg_t    cfg;
  poll_t   poll_q;
  result_t res_d;
  result_t res_q;
  logic    in_valid_q;
  logic    out_valid_q;
  logic    advance;
  logic    step;

  assign advance    = !out_valid_q || out_o.ready;
  assign step       = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;

  clc_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  clc_core #(
    .CODE_LENGTH (CODE_LENGTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .poll_i (poll_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      poll_q.joystick_sample <= in_i.joystick_sample;
      poll_q.enter_press     <= in_i.enter_press;
      poll_q.delete_press    <= in_i.delete_press;
      poll_q.motion_edge     <= in_i.motion_edge;
      poll_q.sound_event     <= in_i.sound_event;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.alarm_mode     = res_q.alarm_mode;
  assign out_o.selected_digit = res_q.selected_digit;
  assign out_o.entered_count  = res_q.entered_count;

endmodule

`default_nettype wire

>>> src/clc_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module clc_cfg import clc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  clc_cfg_if.sink   cfg_i,
  output cfg_t      cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_SECRET_CODE:    cfg_d.secret_code    = cfg_i.data[SECRET_W-1:0];
        CFG_LOW_THRESHOLD:  cfg_d.low_threshold  = cfg_i.data[SAMPLE_W-1:0];
        CFG_HIGH_THRESHOLD: cfg_d.high_threshold = cfg_i.data[SAMPLE_W-1:0];
        CFG_WARMUP_POLLS:   cfg_d.warmup_polls   = cfg_i.data[WARMUP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.secret_code    <= SECRET_RESET;
      cfg_q.low_threshold  <= LOW_RESET;
      cfg_q.high_threshold <= HIGH_RESET;
      cfg_q.warmup_polls   <= WARMUP_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> src/clc_core.sv
`timescale 1ns / 1ps
`default_nettype none

module clc_core import clc_pkg::*; #(
  parameter int CODE_LENGTH = CODE_LENGTH_DEFAULT
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    step_i,
  input  wire poll_t   poll_i,
  input  wire cfg_t    cfg_i,
  output result_t      res_o
);

  localparam int CNT_W = $clog2(CODE_LENGTH + 1);
  localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CODE_LENGTH);

  logic [MODE_W-1:0]   mode_q, mode_d, mode_mid;
  logic [DIGIT_W-1:0]  digit_q, digit_d;
  logic [CNT_W-1:0]    count_q, count_d, count_mid;
  logic                latch_q, latch_d;
  logic [WARMUP_W-1:0] poll_q, poll_d;
  logic [DIGIT_W-1:0]  entry_q [CODE_LENGTH];
  logic [DIGIT_W-1:0]  entry_view [CODE_LENGTH];
  logic [DIGIT_W-1:0]  want [CODE_LENGTH];
  logic [CODE_LENGTH-1:0] digit_ok;

  logic             warm;
  logic             heed;
  logic             intrusion;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic             match;

  assign warm      = poll_q >= cfg_i.warmup_polls;
  assign heed      = (mode_q == MODE_ARMED) && warm;
  assign intrusion = heed && (latch_q || poll_i.motion_edge || poll_i.sound_event);
  assign mode_mid  = intrusion ? MODE_TRIGGERED : mode_q;
  assign latch_d   = heed ? 1'b0 : (latch_q | poll_i.motion_edge);

  always_comb begin
    digit_d = digit_q;
    if (poll_i.joystick_sample < cfg_i.low_threshold) begin
      digit_d = (digit_q == '0) ? DIGIT_MAX : digit_q - 4'd1;
    end else if (poll_i.joystick_sample > cfg_i.high_threshold) begin
      digit_d = (digit_q == DIGIT_MAX) ? '0 : digit_q + 4'd1;
    end
  end

  assign wr_en  = poll_i.enter_press && (count_q < CNT_FULL);
  assign wr_idx = count_q[IDX_W-1:0];

  always_comb begin
    count_mid = count_q;
    if (wr_en) begin
      count_mid = count_mid + 1'b1;
    end
    if (poll_i.delete_press && (count_mid != '0)) begin
      count_mid = count_mid - 1'b1;
    end
  end

  for (genvar i = 0; i < CODE_LENGTH; i++) begin : g_cmp
    if (CODE_LENGTH - 1 - i < SECRET_DIGITS) begin : g_nib
      assign want[i] = cfg_i.secret_code[DIGIT_W*(CODE_LENGTH-1-i) +: DIGIT_W];
    end else begin : g_zero
      assign want[i] = '0;
    end
    assign entry_view[i] = (wr_en && (wr_idx == IDX_W'(i))) ? digit_d : entry_q[i];
    assign digit_ok[i]   = entry_view[i] == want[i];
  end

  assign match = (count_mid == CNT_FULL) && (&digit_ok);

  always_comb begin
    mode_d  = mode_mid;
    count_d = count_mid;
    if (match) begin
      mode_d  = (mode_mid == MODE_DISARMED) ? MODE_ARMED : MODE_DISARMED;
      count_d = '0;
    end
  end

  assign poll_d = (poll_q == '1) ? poll_q : poll_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_ARMED;
      digit_q <= '0;
      count_q <= '0;
      latch_q <= 1'b0;
      poll_q  <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      digit_q <= digit_d;
      count_q <= count_d;
      latch_q <= latch_d;
      poll_q  <= poll_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && wr_en) begin
      entry_q[wr_idx] <= digit_d;
    end
  end

  assign res_o.alarm_mode     = mode_d;
  assign res_o.selected_digit = digit_d;
  assign res_o.entered_count  = COUNT_W'(count_d);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("entry count exceeds code length");

  a_digit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_q <= DIGIT_MAX)
    else $error("selected digit out of decimal range");

  a_trig_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && mode_q == MODE_TRIGGERED) |=>
      (mode_q == MODE_TRIGGERED || mode_q == MODE_DISARMED))
    else $error("triggered mode left to a state other than disarmed");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> ($stable(mode_q) && $stable(count_q) && $stable(poll_q)))
    else $error("state changed without a poll");

endmodule

`default_nettype wire
